// File: src/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types, codes and sizes for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

	localparam int SLOT_COUNT = 1024;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int LINK_W     = $clog2(SLOT_COUNT + 1);
	localparam int REF_W      = 32;
	localparam int GEN_W      = 32;
	localparam int HANDLE_W   = 64;
	localparam int HIDX_W     = 32;

	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOT_COUNT);
	localparam logic [GEN_W-1:0]  GEN_FIRST = GEN_W'(1);

	typedef enum logic [1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_LOOKUP  = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_BAD  = 2'd1,
		STAT_FULL = 2'd2
	} stat_t;

	localparam logic [1:0] STAT_OK_C   = 2'd0;
	localparam logic [1:0] STAT_FULL_C = 2'd2;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic [REF_W-1:0]  obj;
		logic [GEN_W-1:0]  gen;
		logic [LINK_W-1:0] link;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

// File: src/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Generic memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/gha_ctrl.sv
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer: take a command, wait for the slot read, then execute it.
// ----------------------------------------------------------------------------
module gha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output gha_pkg::ctrl_cmd_t cmd
);

	import gha_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

// File: src/gha_dp.sv
// ----------------------------------------------------------------------------
// gha_dp
// Datapath: slot memory, free list head, fill count, checks and result regs.
// ----------------------------------------------------------------------------
module gha_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gha_pkg::ctrl_cmd_t            cmd,
	input  logic [1:0]                    kind,
	input  logic [gha_pkg::REF_W-1:0]     object_ref,
	input  logic [gha_pkg::HANDLE_W-1:0]  handle,
	output logic                          done,
	output logic [gha_pkg::HANDLE_W-1:0]  handle_out,
	output logic [gha_pkg::REF_W-1:0]     object_out,
	output logic [1:0]                    status
);

	import gha_pkg::*;

	logic [1:0]          kind_q;
	logic [REF_W-1:0]    obj_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [IDX_W-1:0]    addr_q;
	logic [LINK_W-1:0]   free_head_q;
	logic [LINK_W-1:0]   used_q;

	logic                done_q;
	logic [HANDLE_W-1:0] hout_q;
	logic [REF_W-1:0]    oout_q;
	logic [1:0]          stat_q;

	logic [IDX_W-1:0]    raddr;
	logic                we;
	logic [IDX_W-1:0]    waddr;
	slot_t               wslot;
	slot_t               rslot;
	logic [SLOT_W-1:0]   rdata;

	logic                free_empty;
	logic                in_range;
	logic                gen_match;
	logic                hit;
	logic [GEN_W-1:0]    gen_inc;
	logic [GEN_W-1:0]    gen_next;
	logic [HIDX_W-1:0]   hidx;

	logic [LINK_W-1:0]   free_head_d;
	logic [LINK_W-1:0]   used_d;
	logic [HANDLE_W-1:0] hout_d;
	logic [REF_W-1:0]    oout_d;
	logic [1:0]          stat_d;

	assign free_empty = (free_head_q == LINK_NONE);

	always_comb begin
		if ((kind == KIND_ALLOC) && !free_empty) begin
			raddr = free_head_q[IDX_W-1:0];
		end else begin
			raddr = handle[IDX_W-1:0];
		end
	end

	gha_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOT_COUNT)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wslot),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rslot     = slot_t'(rdata);
	assign hidx      = handle_q[HIDX_W-1:0];
	assign in_range  = hidx < {{(HIDX_W-LINK_W){1'b0}}, used_q};
	assign gen_match = rslot.gen == handle_q[HANDLE_W-1:HIDX_W];
	assign hit       = in_range && gen_match;
	assign gen_inc   = rslot.gen + GEN_FIRST;
	assign gen_next  = (gen_inc == '0) ? GEN_FIRST : gen_inc;

	always_comb begin
		we          = 1'b0;
		waddr       = addr_q;
		wslot       = rslot;
		free_head_d = free_head_q;
		used_d      = used_q;
		hout_d      = handle_q;
		oout_d      = '0;
		stat_d      = STAT_BAD;
		unique case (kind_q)
			KIND_ALLOC: begin
				if (!free_empty) begin
					we          = 1'b1;
					waddr       = free_head_q[IDX_W-1:0];
					wslot.obj   = obj_q;
					wslot.gen   = rslot.gen;
					wslot.link  = LINK_NONE;
					free_head_d = rslot.link;
					hout_d      = {rslot.gen, {(HIDX_W-IDX_W){1'b0}}, free_head_q[IDX_W-1:0]};
					stat_d      = STAT_OK;
				end else if (used_q != LINK_NONE) begin
					we         = 1'b1;
					waddr      = used_q[IDX_W-1:0];
					wslot.obj  = obj_q;
					wslot.gen  = GEN_FIRST;
					wslot.link = LINK_NONE;
					used_d     = used_q + LINK_W'(1);
					hout_d     = {GEN_FIRST, {(HIDX_W-IDX_W){1'b0}}, used_q[IDX_W-1:0]};
					stat_d     = STAT_OK;
				end else begin
					hout_d = '0;
					stat_d = STAT_FULL;
				end
			end
			KIND_RELEASE: begin
				if (hit) begin
					we          = 1'b1;
					waddr       = addr_q;
					wslot.obj   = '0;
					wslot.gen   = gen_next;
					wslot.link  = free_head_q;
					free_head_d = {1'b0, addr_q};
					stat_d      = STAT_OK;
				end
			end
			KIND_LOOKUP: begin
				if (hit) begin
					oout_d = rslot.obj;
					stat_d = STAT_OK;
				end
			end
			default: begin
				stat_d = STAT_BAD;
			end
		endcase
		we = we && cmd.exec;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind;
			obj_q    <= object_ref;
			handle_q <= handle;
			addr_q   <= handle[IDX_W-1:0];
		end
		if (cmd.exec) begin
			hout_q <= hout_d;
			oout_q <= oout_d;
			stat_q <= stat_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= LINK_NONE;
			used_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) begin
				free_head_q <= free_head_d;
				used_q      <= used_d;
			end
		end
	end

	assign done       = done_q;
	assign handle_out = hout_q;
	assign object_out = oout_q;
	assign status     = stat_q;

endmodule

// File: src/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Generational slot map: allocate, release and look up 64-bit handles.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive kind, object_ref and handle with start; a beat is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: handle_out, object_out and status are shown for exactly
//   one cycle with done high; the receiver cannot stall and must take them.
//   A taken command is held in the command registers while the slot read is
//   registered; the result registers and done are loaded in the execute state,
//   where busy is high for exactly one cycle. No new command is taken while
//   busy is high, as the registered read of the single slot memory is followed
//   by the write-back of the same slot. A new command may be given while done
//   is high. Reset: arst_n low empties the free list and clears the slot count;
//   the slot memory itself is not cleared and needs no sweep, so the block
//   takes commands as soon as reset is released.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   kind,
	input  logic [gha_pkg::REF_W-1:0]    object_ref,
	input  logic [gha_pkg::HANDLE_W-1:0] handle,
	output logic                         done,
	output logic [gha_pkg::HANDLE_W-1:0] handle_out,
	output logic [gha_pkg::REF_W-1:0]    object_out,
	output logic [1:0]                   status
);

	import gha_pkg::*;

	ctrl_cmd_t cmd;

	gha_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd)
	);

	gha_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.kind      (kind),
		.object_ref(object_ref),
		.handle    (handle),
		.done      (done),
		.handle_out(handle_out),
		.object_out(object_out),
		.status    (status)
	);

endmodule

// File: src/gha_chk.sv
// ----------------------------------------------------------------------------
// gha_chk
// Port-level checks for the generational handle allocator, bound to the top.
// ----------------------------------------------------------------------------
module gha_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [gha_pkg::HANDLE_W-1:0] handle_out,
	input logic [gha_pkg::REF_W-1:0]    object_out,
	input logic [1:0]                   status
);

	import gha_pkg::*;

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after a command beat");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result beat missing two cycles after a command beat");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a busy cycle before it");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_FULL_C) |-> (handle_out == '0 && object_out == '0))
		else $error("full status with nonzero payload");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_OK_C && object_out != '0) |-> (handle_out != '0))
		else $error("reference returned with an empty handle");

endmodule

bind generational_handle_allocator gha_chk u_gha_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.handle_out(handle_out),
	.object_out(object_out),
	.status    (status)
);
